### hdl/lnpt_pkg.sv
// Shared types and constants for the lidar nearest-point tracker.
// Used by the decode stage, the tracker stage and the top level.
package lnpt_pkg;

    // Field widths of the scan packet and of the result.
    localparam int BYTE_W   = 8;
    localparam int DIST_W   = 14;
    localparam int ANGLE_W  = 9;
    localparam int LIMIT_W  = 16;
    localparam int CFG_IDX_W = 3;

    // Angle arithmetic.
    localparam logic [ANGLE_W-1:0]   FULL_TURN     = 9'd360;
    localparam logic [ANGLE_W:0]     ONE_TURN_SUM  = 10'd360;
    localparam logic [ANGLE_W:0]     TWO_TURN_SUM  = 10'd720;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DIST_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET  = 3'd4;

    // Configuration reset values.
    localparam logic [LIMIT_W-1:0] DIST_MIN_RESET     = 16'd0;
    localparam logic [LIMIT_W-1:0] DIST_MAX_RESET     = 16'd40000;
    localparam logic [ANGLE_W-1:0] SECTOR_START_RESET = 9'd0;
    localparam logic [ANGLE_W-1:0] SECTOR_END_RESET   = 9'd360;
    localparam logic [ANGLE_W-1:0] ZERO_OFFSET_RESET  = 9'd0;

    // Result kinds.
    localparam logic KIND_REPORT    = 1'b0;
    localparam logic KIND_SYNC_LOST = 1'b1;

    // Configuration as seen by the decode stage.
    typedef struct packed {
        logic [LIMIT_W-1:0] dist_min;
        logic [LIMIT_W-1:0] dist_max;
        logic [ANGLE_W-1:0] sector_start;
        logic [ANGLE_W-1:0] sector_end;
        logic [ANGLE_W-1:0] zero_offset;
    } lnpt_cfg_t;

    // Decoded packet handed from the decode stage to the tracker.
    typedef struct packed {
        logic               sync_err;
        logic               start;
        logic               accept;
        logic [DIST_W-1:0]  range_mm;
        logic [ANGLE_W-1:0] angle;
    } lnpt_point_t;

endpackage

### hdl/lnpt_decode.sv
// Packet decode: sync checks, angle and distance extraction, offset and point filter.
// Pure combinational logic; depends on lnpt_pkg.
module lnpt_decode import lnpt_pkg::*; (
    input  logic [5*BYTE_W-1:0] packet,
    input  lnpt_cfg_t           cfg,
    output lnpt_point_t         point
);

    logic [BYTE_W-1:0]  b_qual;
    logic [BYTE_W-1:0]  b_alo;
    logic [BYTE_W-1:0]  b_ahi;
    logic [BYTE_W-1:0]  b_dlo;
    logic [BYTE_W-1:0]  b_dhi;
    logic [14:0]        angle_fix;
    logic [ANGLE_W-1:0] angle_raw;
    logic [ANGLE_W:0]   angle_sum;
    logic [ANGLE_W-1:0] angle;
    logic [DIST_W-1:0]  range_mm;
    logic [5:0]         quality;
    logic               full_circle;
    logic               in_sector;
    logic               in_limits;

    assign b_qual = packet[0*BYTE_W +: BYTE_W];
    assign b_alo  = packet[1*BYTE_W +: BYTE_W];
    assign b_ahi  = packet[2*BYTE_W +: BYTE_W];
    assign b_dlo  = packet[3*BYTE_W +: BYTE_W];
    assign b_dhi  = packet[4*BYTE_W +: BYTE_W];

    // Start bit must be the complement of the not-start bit, and the check bit set.
    assign point.sync_err = (b_qual[0] == b_qual[1]) || !b_alo[0];
    assign point.start    = b_qual[0];
    assign quality        = b_qual[7:2];

    // Fixed-point to whole units: q6 angle and q2 distance are plain shifts.
    assign angle_fix = {b_ahi, b_alo[7:1]};
    assign angle_raw = angle_fix[14:6];
    assign range_mm  = {b_dhi, b_dlo[7:2]};

    // The offset sum stays below three turns, so two compares reduce it.
    assign angle_sum = {1'b0, angle_raw} + {1'b0, cfg.zero_offset};
    always_comb begin
        if (cfg.zero_offset == '0) begin
            angle = angle_raw;
        end else if (angle_sum >= TWO_TURN_SUM) begin
            angle = ANGLE_W'(angle_sum - TWO_TURN_SUM);
        end else if (angle_sum >= ONE_TURN_SUM) begin
            angle = ANGLE_W'(angle_sum - ONE_TURN_SUM);
        end else begin
            angle = angle_sum[ANGLE_W-1:0];
        end
    end

    // Sector test: full circle, normal range or wrapped range.
    assign full_circle = (cfg.sector_start == '0) && (cfg.sector_end == FULL_TURN);
    always_comb begin
        if (full_circle) begin
            in_sector = 1'b1;
        end else if (cfg.sector_start <= cfg.sector_end) begin
            in_sector = (angle >= cfg.sector_start) && (angle <= cfg.sector_end);
        end else begin
            in_sector = (angle >= cfg.sector_start) || (angle <= cfg.sector_end);
        end
    end

    assign in_limits = ({2'b00, range_mm} >= cfg.dist_min)
                    && ({2'b00, range_mm} <= cfg.dist_max);

    assign point.accept   = (range_mm != '0) && (quality != '0) && in_sector && in_limits;
    assign point.range_mm = range_mm;
    assign point.angle    = angle;

endmodule

### hdl/lnpt_tracker.sv
// Rotation tracking state and the result register with its stream handshake.
// Depends on lnpt_pkg; fed by lnpt_decode through the input register of the top level.
module lnpt_tracker import lnpt_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  lnpt_point_t         point,
    output logic                item_take,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,   // nearest_dist[13:0], nearest_angle[22:14], zero
    output logic                m_tuser    // result_kind
);

    logic               have_point_reg, have_point_next;
    logic [DIST_W-1:0]  best_dist_reg, best_dist_next;
    logic [ANGLE_W-1:0] best_angle_reg, best_angle_next;
    logic               m_valid_reg, m_valid_next;
    logic               kind_reg, kind_next;
    logic [DIST_W-1:0]  out_dist_reg, out_dist_next;
    logic [ANGLE_W-1:0] out_angle_reg, out_angle_next;
    logic               base_have;
    logic               emit;

    // An item is processed whenever the result register is free or being drained.
    assign item_take = item_valid && (!m_valid_reg || m_tready);

    // Tracking update and result selection for the item being processed.
    always_comb begin
        have_point_next = have_point_reg;
        best_dist_next  = best_dist_reg;
        best_angle_next = best_angle_reg;
        kind_next       = kind_reg;
        out_dist_next   = out_dist_reg;
        out_angle_next  = out_angle_reg;
        emit            = 1'b0;
        base_have       = have_point_reg;
        if (item_take) begin
            if (point.sync_err) begin
                emit            = 1'b1;
                kind_next       = KIND_SYNC_LOST;
                out_dist_next   = '0;
                out_angle_next  = '0;
                have_point_next = 1'b0;
                best_dist_next  = '1;
                best_angle_next = '0;
            end else begin
                // A start packet closes the previous rotation first.
                if (point.start) begin
                    emit           = have_point_reg;
                    kind_next      = KIND_REPORT;
                    out_dist_next  = best_dist_reg;
                    out_angle_next = best_angle_reg;
                    base_have      = 1'b0;
                    have_point_next = 1'b0;
                    best_dist_next  = '1;
                    best_angle_next = '0;
                end
                if (point.accept && (!base_have || (point.range_mm < best_dist_reg))) begin
                    have_point_next = 1'b1;
                    best_dist_next  = point.range_mm;
                    best_angle_next = point.angle;
                end
            end
        end
    end

    always_comb begin
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_point_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            have_point_reg <= have_point_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload; the best distance is only used while a point is held.
    always_ff @(posedge aclk) begin
        best_dist_reg  <= best_dist_next;
        best_angle_reg <= best_angle_next;
        kind_reg       <= kind_next;
        out_dist_reg   <= out_dist_next;
        out_angle_reg  <= out_angle_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {1'b0, out_angle_reg, out_dist_reg};

    // A sync loss always drops the tracked point.
    a_sync_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        item_take && point.sync_err |=> !have_point_reg)
        else $error("tracking not cleared after sync loss");

    // A rotation report is only produced while a point is held.
    a_report_has_point: assert property (@(posedge aclk) disable iff (!aresetn)
        item_take && !point.sync_err && point.start && !have_point_reg |=> !m_valid_reg)
        else $error("report issued without a tracked point");

    // An accepted point on a valid packet always leaves a point tracked.
    a_accept_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        item_take && !point.sync_err && point.accept |=> have_point_reg)
        else $error("accepted point not tracked");

    // Sync-lost results carry zero fields.
    a_sync_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (kind_reg == KIND_SYNC_LOST) |-> (out_dist_reg == '0)
            && (out_angle_reg == '0))
        else $error("sync-lost result with nonzero fields");

endmodule

### hdl/lidar_nearest_point_tracker_core.sv
// Top level of the lidar nearest-point tracker: input register, configuration registers.
// Instantiates lnpt_decode and lnpt_tracker; depends on lnpt_pkg.
//
// Takes one 5-byte scan packet per transfer on the s_ channel and gives at most one result
// per packet on the m_ channel: a nearest-point report when a start packet closes a
// rotation that held a point, or a sync-lost result for a packet that fails its start or
// check bit. Each packet is registered, then decoded and compared against the tracked point
// in a single pass, and the result register is loaded on the next edge, so one packet can
// be accepted in every cycle while m_tready is high. A result is held in the result register
// after its packet leaves the input register; while a result waits with m_tready low, the
// input holds. Configuration is written through cfg_we, cfg_addr and cfg_wdata, by the user
// only while the block is idle (not enforced by the block); unused indexes are ignored.
module lidar_nearest_point_tracker_core import lnpt_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,  // byte_quality, byte_angle_low, byte_angle_high,
                                           // byte_dist_low, byte_dist_high
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,  // nearest_dist[13:0], nearest_angle[22:14], zero
    output logic                 m_tuser,  // result_kind
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [LIMIT_W-1:0]   cfg_wdata
);

    logic                in_valid_reg, in_valid_next;
    logic [5*BYTE_W-1:0] in_data_reg, in_data_next;
    lnpt_cfg_t           cfg_reg, cfg_next;
    lnpt_point_t         point;
    logic                item_take;

    // Input register refills as soon as its packet is processed.
    assign s_tready = !in_valid_reg || item_take;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_data_next  = s_tdata;
        end
    end

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_DIST_MIN:     cfg_next.dist_min     = cfg_wdata;
                REG_DIST_MAX:     cfg_next.dist_max     = cfg_wdata;
                REG_SECTOR_START: cfg_next.sector_start = cfg_wdata[ANGLE_W-1:0];
                REG_SECTOR_END:   cfg_next.sector_end   = cfg_wdata[ANGLE_W-1:0];
                REG_ZERO_OFFSET:  cfg_next.zero_offset  = cfg_wdata[ANGLE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg         <= 1'b0;
            cfg_reg.dist_min     <= DIST_MIN_RESET;
            cfg_reg.dist_max     <= DIST_MAX_RESET;
            cfg_reg.sector_start <= SECTOR_START_RESET;
            cfg_reg.sector_end   <= SECTOR_END_RESET;
            cfg_reg.zero_offset  <= ZERO_OFFSET_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            cfg_reg      <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_data_reg <= in_data_next;
    end

    lnpt_decode u_decode (
        .packet (in_data_reg),
        .cfg    (cfg_reg),
        .point  (point)
    );

    lnpt_tracker u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (in_valid_reg),
        .point      (point),
        .item_take  (item_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

### tb/sv/tb.sv
// Self-checking testbench for lidar_nearest_point_tracker_core.
// Runs a directed table of scan packets and then randomized phases under several register
// settings, and checks every result against a local tracker model. Depends on lnpt_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lnpt_pkg::*;

    // Index outside the register map; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 150;
    localparam int SETTLE_CYCLES = 6;

    typedef struct packed {
        logic               kind;
        logic [DIST_W-1:0]  range_mm;
        logic [ANGLE_W-1:0] angle;
    } tracker_result_t;

    typedef enum {
        ROW_PREDICT,    // expected result comes from the tracker model
        ROW_NO_RESULT,  // typed in: no result
        ROW_RESULT,     // typed in: exactly the given result
        ROW_WRITE       // register write between packets
    } row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [39:0]              pkt;
        tracker_result_t          res;
        logic [CFG_IDX_W-1:0]     idx;
        logic [LIMIT_W-1:0]       val;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [39:0]          s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;
    logic                 m_tuser;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [LIMIT_W-1:0]   cfg_wdata = '0;

    // Register shadow and tracking state of the model.
    logic [LIMIT_W-1:0] lim_min    = DIST_MIN_RESET;
    logic [LIMIT_W-1:0] lim_max    = DIST_MAX_RESET;
    logic [ANGLE_W-1:0] sec_lo     = SECTOR_START_RESET;
    logic [ANGLE_W-1:0] sec_hi     = SECTOR_END_RESET;
    logic [ANGLE_W-1:0] ang_offset = ZERO_OFFSET_RESET;
    logic [15:0]        best_mm    = 16'hFFFF;
    logic [ANGLE_W-1:0] best_deg   = '0;
    bit                 have_best  = 1'b0;

    tracker_result_t pending_results[$];
    stim_row_t       script[$];

    int  fail_count    = 0;
    int  pkt_count     = 0;
    int  report_seen   = 0;
    int  sync_seen     = 0;
    int  setting_count = 0;
    int  burst_left    = 0;
    bit  sending       = 1'b0;

    lidar_nearest_point_tracker_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Overall time limit.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Packs the five packet bytes, byte 0 in the lowest bits.
    function automatic logic [39:0] mk_pkt(input logic [5:0] qual, input bit st, input bit nst,
                                           input bit chk, input logic [14:0] q6,
                                           input logic [15:0] dq2);
        return {dq2, q6[14:7], q6[6:0], chk, qual, nst, st};
    endfunction

    function automatic tracker_result_t mk_res(input logic kind, input int mm, input int ang);
        tracker_result_t r;
        r.kind     = kind;
        r.range_mm = mm[DIST_W-1:0];
        r.angle    = ang[ANGLE_W-1:0];
        return r;
    endfunction

    function automatic bit sector_hit(input int unsigned ang);
        if (sec_lo == 0 && sec_hi == FULL_TURN)
            return 1'b1;
        if (sec_lo <= sec_hi)
            return ang >= sec_lo && ang <= sec_hi;
        return ang >= sec_lo || ang <= sec_hi;
    endfunction

    function automatic void clear_best();
        best_mm   = 16'hFFFF;
        best_deg  = '0;
        have_best = 1'b0;
    endfunction

    // Tracker model: updates the nearest point and says whether the packet closes with a result.
    task automatic track_packet(input logic [39:0] p, output bit has, output tracker_result_t r);
        logic [7:0]  b0, b1, b2, b3, b4;
        logic [14:0] q6;
        int unsigned ang, pt_mm;
        bit          keep;
        {b4, b3, b2, b1, b0} = p;
        has = 1'b0;
        r   = '0;
        if (b0[0] == b0[1] || !b1[0]) begin
            // Broken sync: report it and forget the rotation.
            has    = 1'b1;
            r.kind = KIND_SYNC_LOST;
            clear_best();
        end else begin
            // A start packet closes the previous rotation first.
            if (b0[0]) begin
                if (have_best) begin
                    has        = 1'b1;
                    r.kind     = KIND_REPORT;
                    r.range_mm = best_mm[DIST_W-1:0];
                    r.angle    = best_deg;
                end
                clear_best();
            end
            q6    = {b2, b1[7:1]};
            ang   = q6 / 64;
            pt_mm = {b4, b3} / 4;
            if (ang_offset != 0)
                ang = (ang + ang_offset) % 360;
            keep = pt_mm != 0 && b0[7:2] != 0 && sector_hit(ang)
                   && pt_mm >= lim_min && pt_mm <= lim_max;
            if (keep && pt_mm < best_mm) begin
                best_mm   = pt_mm[15:0];
                best_deg  = ang[ANGLE_W-1:0];
                have_best = 1'b1;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input tracker_result_t want,
                                   input tracker_result_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected kind %0d dist %0d angle %0d, got kind %0d dist %0d angle %0d",
                     $realtime, what, want.kind, want.range_mm, want.angle,
                     got.kind, got.range_mm, got.angle);
    endtask

    // Writes one register and keeps the shadow in step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_DIST_MIN:     lim_min    = val;
            REG_DIST_MAX:     lim_max    = val;
            REG_SECTOR_START: sec_lo     = val[ANGLE_W-1:0];
            REG_SECTOR_END:   sec_hi     = val[ANGLE_W-1:0];
            REG_ZERO_OFFSET:  ang_offset = val[ANGLE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic finish_writes();
        cfg_we <= 1'b0;
        setting_count++;
        repeat (2) @(posedge aclk);
    endtask

    // Stops sending and waits until the block has nothing left in flight.
    task automatic drain();
        if (sending) begin
            s_tvalid <= 1'b0;
            sending = 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Sends one packet, records what it should produce, then maybe ends the burst.
    task automatic push_item(input logic [39:0] pkt, input row_kind_t mode,
                             input tracker_result_t typed);
        bit              has;
        tracker_result_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= pkt;
        sending = 1'b1;
        do @(posedge aclk); while (!s_tready);
        track_packet(pkt, has, r);
        if (mode == ROW_RESULT)
            pending_results.push_back(typed);
        else if (mode == ROW_PREDICT && has)
            pending_results.push_back(r);
        pkt_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            sending = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic add_pkt(input row_kind_t mode, input logic [39:0] pkt,
                           input tracker_result_t res);
        stim_row_t row;
        row.kind = mode;
        row.pkt  = pkt;
        row.res  = res;
        row.idx  = '0;
        row.val  = '0;
        script.push_back(row);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
        stim_row_t row;
        row.kind = ROW_WRITE;
        row.pkt  = '0;
        row.res  = '0;
        row.idx  = idx;
        row.val  = val;
        script.push_back(row);
    endtask

    // Directed packets: sync errors, extremes, rotation handling, limits with offset.
    task automatic build_script();
        tracker_result_t lost;
        tracker_result_t none;
        lost = mk_res(KIND_SYNC_LOST, 0, 0);
        none = '0;
        // Start and not-start bits equal, both ways; then a cleared check bit.
        add_pkt(ROW_RESULT,    mk_pkt(6'd0, 1'b0, 1'b0, 1'b1, 15'd0, 16'd0), lost);
        add_pkt(ROW_RESULT,    mk_pkt(6'd63, 1'b1, 1'b1, 1'b1, 15'h7FFF, 16'hFFFF), lost);
        add_pkt(ROW_RESULT,    mk_pkt(6'd1, 1'b0, 1'b1, 1'b0, 15'd64, 16'd400), lost);
        // A start packet with nothing tracked gives no result but opens a rotation.
        add_pkt(ROW_NO_RESULT, mk_pkt(6'd1, 1'b1, 1'b0, 1'b1, 15'd0, 16'd40), none);
        add_pkt(ROW_RESULT,    mk_pkt(6'd1, 1'b1, 1'b0, 1'b1, 15'd0, 16'd0),
                mk_res(KIND_REPORT, 10, 0));
        // Largest raw angle and distance, reported unchanged without an offset.
        add_pkt(ROW_NO_RESULT, mk_pkt(6'd63, 1'b0, 1'b1, 1'b1, 15'h7FFF, 16'hFFFF), none);
        add_pkt(ROW_RESULT,    mk_pkt(6'd0, 1'b1, 1'b0, 1'b1, 15'd0, 16'd0),
                mk_res(KIND_REPORT, 16383, 511));
        // Zero quality, then nearer and equal points within one rotation.
        add_pkt(ROW_PREDICT, mk_pkt(6'd0, 1'b0, 1'b1, 1'b1, 15'd64, 16'd272), none);
        add_pkt(ROW_PREDICT, mk_pkt(6'd5, 1'b0, 1'b1, 1'b1, 15'd64, 16'd272), none);
        add_pkt(ROW_PREDICT, mk_pkt(6'd5, 1'b0, 1'b1, 1'b1, 15'(90 * 64), 16'd400), none);
        add_pkt(ROW_PREDICT, mk_pkt(6'd5, 1'b0, 1'b1, 1'b1, 15'(200 * 64 + 63), 16'd12), none);
        add_pkt(ROW_PREDICT, mk_pkt(6'd5, 1'b0, 1'b1, 1'b1, 15'(201 * 64), 16'd15), none);
        add_pkt(ROW_PREDICT, mk_pkt(6'd1, 1'b1, 1'b0, 1'b1, 15'd0, 16'd0), none);
        // A sync loss in mid-rotation drops the tracked point.
        add_pkt(ROW_PREDICT,   mk_pkt(6'd5, 1'b0, 1'b1, 1'b1, 15'(10 * 64), 16'd200), none);
        add_pkt(ROW_RESULT,    mk_pkt(6'd5, 1'b0, 1'b1, 1'b0, 15'(10 * 64), 16'd200), lost);
        add_pkt(ROW_NO_RESULT, mk_pkt(6'd1, 1'b1, 1'b0, 1'b1, 15'd0, 16'd0), none);
        // Narrow distance window, wrapped sector and the largest offset.
        add_write(REG_DIST_MIN, 16'd20);
        add_write(REG_DIST_MAX, 16'd30);
        add_write(REG_SECTOR_START, 16'd300);
        add_write(REG_SECTOR_END, 16'd40);
        add_write(REG_ZERO_OFFSET, 16'd511);
        add_write(REG_UNUSED, 16'hFFFF);
        add_pkt(ROW_PREDICT, mk_pkt(6'd9, 1'b0, 1'b1, 1'b1, 15'd0, 16'd100), none);
        add_pkt(ROW_PREDICT, mk_pkt(6'd9, 1'b0, 1'b1, 1'b1, 15'h7FFF, 16'd100), none);
        add_pkt(ROW_PREDICT, mk_pkt(6'd9, 1'b0, 1'b1, 1'b1, 15'(209 * 64), 16'd76), none);
        add_pkt(ROW_PREDICT, mk_pkt(6'd9, 1'b0, 1'b1, 1'b1, 15'(209 * 64), 16'd124), none);
        add_pkt(ROW_PREDICT, mk_pkt(6'd9, 1'b0, 1'b1, 1'b1, 15'(250 * 64), 16'd80), none);
        add_pkt(ROW_PREDICT, mk_pkt(6'd9, 1'b0, 1'b1, 1'b1, 15'(249 * 64), 16'd120), none);
        add_pkt(ROW_PREDICT, mk_pkt(6'd1, 1'b1, 1'b0, 1'b1, 15'd0, 16'd0), none);
    endtask

    // One register setting per random phase; the first few are fixed extremes.
    task automatic apply_settings(input int phase);
        int dmin, dmax, slo, shi, off;
        case (phase)
            0: begin dmin = 0;     dmax = 65535; slo = 0;   shi = 360; off = 1;   end
            1: begin dmin = 40000; dmax = 40000; slo = 0;   shi = 0;   off = 359; end
            2: begin dmin = 65535; dmax = 65535; slo = 511; shi = 0;   off = 511; end
            3: begin dmin = 0;     dmax = 40000; slo = 360; shi = 360; off = 360; end
            4: begin
                dmin = $urandom_range(0, 2000);
                dmax = $urandom_range(4000, 16383);
                slo  = $urandom_range(181, 360);
                shi  = $urandom_range(0, 180);
                off  = 0;
            end
            5: begin dmin = 0;     dmax = 40000; slo = 0;   shi = 360; off = 0;   end
            default: begin
                dmin = $urandom_range(0, 8000);
                dmax = $urandom_range(dmin, 40000);
                slo  = $urandom_range(0, 360);
                shi  = $urandom_range(0, 360);
                off  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 360);
            end
        endcase
        write_reg(REG_DIST_MIN, dmin[15:0]);
        write_reg(REG_DIST_MAX, dmax[15:0]);
        write_reg(REG_SECTOR_START, slo[15:0]);
        write_reg(REG_SECTOR_END, shi[15:0]);
        write_reg(REG_ZERO_OFFSET, off[15:0]);
    endtask

    // Mostly well-formed rotations with random content, plus raw noise and bad check bits.
    function automatic logic [39:0] random_packet();
        int          pick, lo, hi, mm;
        bit          st, chk;
        logic [5:0]  qual;
        logic [14:0] q6;
        logic [15:0] dq2;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return {8'($urandom), 32'($urandom)};
        st   = ($urandom_range(0, 15) == 0);
        chk  = ($urandom_range(0, 39) != 0);
        qual = ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
        q6   = 15'($urandom_range(0, 32767));
        lo   = lim_min;
        hi   = (lim_max > 16383) ? 16383 : lim_max;
        if (pick < 60 && lo <= hi) begin
            mm  = $urandom_range(lo, hi);
            dq2 = 16'(mm * 4 + $urandom_range(0, 3));
        end else if (pick < 63) begin
            dq2 = 16'($urandom_range(0, 3));
        end else begin
            dq2 = 16'($urandom_range(0, 65535));
        end
        return mk_pkt(qual, st, !st, chk, q6, dq2);
    endfunction

    // Receiver: steady stretches, light random stalls and longer stall runs.
    initial begin
        int mode, len;
        forever begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(10, 60);
            for (int c = 0; c < len; c++) begin
                @(posedge aclk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 2) != 0);
                    default: m_tready <= ((c % 9) < 3);
                endcase
            end
        end
    end

    // Result checker: each transfer on the result side against the oldest expectation.
    always @(posedge aclk) begin
        tracker_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[13:0], m_tdata[22:14]};
            if (got.kind == KIND_REPORT)
                report_seen++;
            else
                sync_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    // Stimulus: reset, directed table, random phases, then the final check.
    initial begin
        int w;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        build_script();
        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE) begin
                if (i == 0 || script[i-1].kind != ROW_WRITE)
                    drain();
                write_reg(script[i].idx, script[i].val);
                if (i == script.size() - 1 || script[i+1].kind != ROW_WRITE)
                    finish_writes();
            end else begin
                push_item(script[i].pkt, script[i].kind, script[i].res);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            apply_settings(phase);
            finish_writes();
            repeat (PHASE_ITEMS) push_item(random_packet(), ROW_PREDICT, '0);
        end

        if (sending)
            s_tvalid <= 1'b0;
        for (w = 0; w < 5000 && pending_results.size() != 0; w++)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (pending_results.size() != 0)
            report_mismatch("result never arrived", pending_results.pop_front(), '0);

        $display("Sent %0d scan packets under %0d register settings.", pkt_count, setting_count);
        $display("Checked %0d rotation reports and %0d sync-lost results, %0d failures.",
                 report_seen, sync_seen, fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
